// ===== rtl/core/chd_pkg.sv =====
// Shared types and constants for the HTTP chunked body decoder.
// Holds the item structs, status codes and decoder phase encoding; no dependencies.
`timescale 1ns / 1ps

package chd_pkg;

  // Largest number of hex digits a chunk size line may ever carry.
  localparam int SIZE_DIGITS_MAX = 8;
  // Width of the chunk size accumulator and byte countdown.
  localparam int SIZE_W = 32;
  // Width of the size line digit counter and the digit limit register.
  localparam int DCNT_W = 4;
  // Reset value of the digit limit register.
  localparam logic [DCNT_W-1:0] DIGITS_RESET = DCNT_W'(5);

  // Line terminator characters.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Status codes reported with every result item.
  localparam logic [1:0] STATUS_RUN   = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Decoder phase.
  typedef enum logic [3:0] {
    PH_SIZE    = 4'd0,
    PH_SIZE_LF = 4'd1,
    PH_DATA    = 4'd2,
    PH_DATA_CR = 4'd3,
    PH_DATA_LF = 4'd4,
    PH_END_CR  = 4'd5,
    PH_END_LF  = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  // One raw input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } in_item_t;

  // One decoded result item.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
  } out_item_t;

endpackage

// ===== rtl/core/chd_fsm.sv =====
// Chunked body framing state machine: phase, size accumulator and byte countdown.
// Processes one item per enabled cycle; depends on chd_pkg.
`timescale 1ns / 1ps

module chd_fsm (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  chd_pkg::in_item_t        item,
  input  logic [chd_pkg::DCNT_W-1:0] max_digits,
  output chd_pkg::out_item_t       result
);
  import chd_pkg::*;

  phase_t              phase, phase_next;
  logic [SIZE_W-1:0]   size_accum, size_accum_next;
  logic [DCNT_W-1:0]   digit_count, digit_count_next;
  logic [SIZE_W-1:0]   bytes_left, bytes_left_next;

  // State seen by this item: a start request clears it first.
  phase_t              cur_phase;
  logic [SIZE_W-1:0]   cur_accum;
  logic [DCNT_W-1:0]   cur_count;
  logic [SIZE_W-1:0]   cur_left;

  logic                hex_ok;
  logic [3:0]          hex_val;
  logic [DCNT_W-1:0]   digit_limit;
  logic [SIZE_W-1:0]   left_dec;

  // Hex digit decode of the incoming byte.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39) begin
      hex_val = 4'(item.in_byte - 8'h30);
    end else if (item.in_byte >= 8'h61 && item.in_byte <= 8'h66) begin
      hex_val = 4'(item.in_byte - 8'h57);
    end else if (item.in_byte >= 8'h41 && item.in_byte <= 8'h46) begin
      hex_val = 4'(item.in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Clamp the configured digit limit into the supported range.
  always_comb begin
    if (max_digits == '0) begin
      digit_limit = DCNT_W'(1);
    end else if (max_digits > DCNT_W'(SIZE_DIGITS_MAX)) begin
      digit_limit = DCNT_W'(SIZE_DIGITS_MAX);
    end else begin
      digit_limit = max_digits;
    end
  end

  // Select cleared or live state depending on the start flag.
  always_comb begin
    if (item.start_req) begin
      cur_phase = PH_SIZE;
      cur_accum = '0;
      cur_count = '0;
      cur_left  = '0;
    end else begin
      cur_phase = phase;
      cur_accum = size_accum;
      cur_count = digit_count;
      cur_left  = bytes_left;
    end
  end

  assign left_dec = cur_left - SIZE_W'(1);

  // Next state and result for the current item.
  always_comb begin
    phase_next       = cur_phase;
    size_accum_next  = cur_accum;
    digit_count_next = cur_count;
    bytes_left_next  = cur_left;
    result.payload_valid = 1'b0;
    result.payload_byte  = 8'd0;

    case (cur_phase)
      PH_SIZE: begin
        if (hex_ok) begin
          if (cur_count >= digit_limit) begin
            phase_next = PH_ERROR;
          end else begin
            size_accum_next  = (cur_accum << 4) | SIZE_W'(hex_val);
            digit_count_next = cur_count + DCNT_W'(1);
          end
        end else if (item.in_byte == CH_CR && cur_count != '0) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SIZE_LF: begin
        if (item.in_byte != CH_LF) begin
          phase_next = PH_ERROR;
        end else if (cur_accum == '0) begin
          phase_next = PH_END_CR;
        end else begin
          bytes_left_next = cur_accum;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = item.in_byte;
        bytes_left_next      = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        phase_next = (item.in_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        if (item.in_byte == CH_LF) begin
          phase_next       = PH_SIZE;
          size_accum_next  = '0;
          digit_count_next = '0;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_END_CR: begin
        phase_next = (item.in_byte == CH_CR) ? PH_END_LF : PH_ERROR;
      end
      PH_END_LF: begin
        phase_next = (item.in_byte == CH_LF) ? PH_DONE : PH_ERROR;
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase

    if (phase_next == PH_DONE) begin
      result.status = STATUS_DONE;
    end else if (phase_next == PH_ERROR) begin
      result.status = STATUS_ERROR;
    end else begin
      result.status = STATUS_RUN;
    end
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIZE;
      size_accum  <= '0;
      digit_count <= '0;
      bytes_left  <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      size_accum  <= size_accum_next;
      digit_count <= digit_count_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

// ===== rtl/core/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder: input register, framing FSM, result register.
// Depends on chd_pkg and chd_fsm.
`timescale 1ns / 1ps

// Decodes a chunked HTTP/1.1 body one byte per item and returns exactly one result
// item for each input item: the payload byte when the input byte is chunk data, and
// a status of in progress, body complete or framing error. Complete and error are
// sticky until an item with start_req set, which restarts decoding at that byte.
// The block sustains one item per clock cycle while out_stall is low. A result item
// passes through the input and result registers, waiting in the input register
// while the result register is stalled. The rate is set by the per-item update of
// the FSM phase, size and countdown registers. The digit limit register (cfg_wdata,
// reset 5, clamped to 1..8) should be written only while no items are in flight.
module http_chunked_body_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [chd_pkg::DCNT_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  chd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output chd_pkg::out_item_t            out_data
);
  import chd_pkg::*;

  logic [DCNT_W-1:0] max_digits;
  logic              s1_valid;
  in_item_t          s1_item;
  out_item_t         fsm_result;
  logic              advance;
  logic              in_take;

  // The held item moves on when the result register is free or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Digit limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_digits <= DIGITS_RESET;
    end else if (cfg_we) begin
      max_digits <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_data;
    end
  end

  chd_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (s1_item),
    .max_digits (max_digits),
    .result     (fsm_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= fsm_result;
    end
  end

endmodule

// ===== rtl/core/chd_checker.sv =====
// Port-level checks for the HTTP chunked body decoder, bound to the top level.
// Depends on chd_pkg and http_chunked_body_decoder.
`timescale 1ns / 1ps

module chd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input chd_pkg::out_item_t         out_data
);
  import chd_pkg::*;

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // The input side only stalls when a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // A payload byte is only delivered while the body is still in progress.
  a_payload_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.payload_valid |-> out_data.status == STATUS_RUN)
    else $error("payload byte with terminal status");

  // Non-payload results carry a zero byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
    else $error("payload byte set without payload_valid");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
